@@ hw/rtl/ljsm_pkg.sv @@
// Shared types and constants for the latency/jitter statistics monitor.
// No dependencies.
package ljsm_pkg;

  localparam int SNAP_W   = 32;
  localparam int STAMP_W  = 64;
  localparam int SLOT_W   = 10;
  localparam int LIMIT_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [SNAP_W-1:0]  PERIOD_RST = 32'd110;

  typedef enum logic [0:0] {
    REQ_TIMER = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_PERIOD = 1'b0,
    CFG_SPIKE_LIMIT  = 1'b1
  } cfg_idx_t;

endpackage

@@ hw/rtl/ljsm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ljsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/latency_jitter_stats_monitor.sv @@
// Latency/jitter statistics monitor top level.
// Depends on ljsm_pkg and ljsm_ram (latency ring storage).
// An accepted word is registered in the output stage that drives the out_ channel.
// Throughput: one word per cycle unless out_ready stalls a full output stage.
// Reset (rst_n low, synchronous): stats and registers to reset values, output empty.
// The latency ring RAM is not cleared; there is no clearing pass.
module latency_jitter_stats_monitor
  import ljsm_pkg::*;
#(
  parameter int RING_DEPTH   = 1024,
  parameter int TICKS_PER_US = 125
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [SNAP_W-1:0]     in_timer_snapshot,
  input  logic [STAMP_W-1:0]    in_event_timestamp,
  input  logic [SLOT_W-1:0]     in_read_slot,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SNAP_W-1:0]     out_latency_now,
  output logic                  out_spike_seen,
  output logic [SNAP_W-1:0]     out_latency_low,
  output logic [SNAP_W-1:0]     out_latency_high,
  output logic [STAMP_W-1:0]    out_latency_total,
  output logic [STAMP_W-1:0]    out_gap_now,
  output logic [STAMP_W-1:0]    out_gap_low,
  output logic [STAMP_W-1:0]    out_gap_high,
  output logic [STAMP_W-1:0]    out_gap_total,
  output logic [STAMP_W-1:0]    out_events_done,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int TH_W = LIMIT_W + $clog2(TICKS_PER_US + 1);
  localparam logic [STAMP_W-1:0] ALL_ONES = '1;
  localparam logic [AW-1:0] FIRST_SLOT = AW'(ALL_ONES % RING_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(RING_DEPTH - 1);
  localparam int SEG_W = SLOT_W / 2;
  localparam int SEG_N = 1 << SEG_W;
  localparam int HI_N  = 1 << (SLOT_W - SEG_W);

  // configuration
  logic [SNAP_W-1:0] period_r;
  logic [TH_W-1:0]   thresh_r;

  // running state
  logic               started_r;
  logic [STAMP_W-1:0] prev_r;
  logic [STAMP_W-1:0] cnt_r;
  logic [SNAP_W-1:0]  lat_min_r, lat_max_r;
  logic [STAMP_W-1:0] lat_sum_r;
  logic [STAMP_W-1:0] jit_min_r, jit_max_r, jit_sum_r;
  logic [AW-1:0]      slot_r;

  // output stage
  logic               s1_valid_r;
  logic               s1_read_r;
  logic [SNAP_W-1:0]  s1_word_r;
  logic [STAMP_W-1:0] s1_gap_r;
  logic               s1_spike_r;

  logic               acc, ev, rd, first;
  logic [SNAP_W-1:0]  word;
  logic [STAMP_W-1:0] gap, cnt_base, lsum_base, jsum_base;
  logic [AW-1:0]      slot_use, slot_nxt;
  logic               spike;
  logic [SNAP_W-1:0]  ram_rdata;

  logic [AW-1:0] hi_tab [HI_N];
  logic [AW-1:0] lo_tab [SEG_N];
  logic [AW:0]   rslot_sum;
  logic [AW-1:0] rslot;

  for (genvar g = 0; g < HI_N; g++) begin : g_hi_tab
    assign hi_tab[g] = AW'((g * SEG_N) % RING_DEPTH);
  end
  for (genvar g = 0; g < SEG_N; g++) begin : g_lo_tab
    assign lo_tab[g] = AW'(g % RING_DEPTH);
  end

  // read_slot mod depth: two small tables and one correction
  always_comb begin
    rslot_sum = {1'b0, hi_tab[in_read_slot[SLOT_W-1:SEG_W]]}
              + {1'b0, lo_tab[in_read_slot[SEG_W-1:0]]};
    if (rslot_sum >= (AW+1)'(RING_DEPTH)) begin
      rslot = AW'(rslot_sum - (AW+1)'(RING_DEPTH));
    end else begin
      rslot = AW'(rslot_sum);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign ev        = acc && (req_t'(in_req_type) == REQ_TIMER);
  assign rd        = acc && (req_t'(in_req_type) == REQ_READ);
  assign first     = !started_r;

  always_comb begin
    word      = period_r - in_timer_snapshot;
    cnt_base  = first ? '0 : cnt_r;
    lsum_base = first ? '0 : lat_sum_r;
    jsum_base = first ? '0 : jit_sum_r;
    gap       = first ? '0 : in_event_timestamp - prev_r;
    slot_use  = (cnt_base == '0) ? FIRST_SLOT : slot_r;
    if (cnt_base == '0 || slot_use == LAST_SLOT) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_use + AW'(1);
    end
    spike = (thresh_r != '0) && (word >= SNAP_W'(thresh_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      thresh_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TIMER_PERIOD: period_r <= cfg_data[SNAP_W-1:0];
        CFG_SPIKE_LIMIT:  thresh_r <= TH_W'(cfg_data[LIMIT_W-1:0] * TICKS_PER_US);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      prev_r    <= '0;
      cnt_r     <= '0;
      lat_min_r <= '1;
      lat_max_r <= '0;
      lat_sum_r <= '0;
      jit_min_r <= '1;
      jit_max_r <= '0;
      jit_sum_r <= '0;
      slot_r    <= '0;
    end else if (ev) begin
      started_r <= 1'b1;
      prev_r    <= in_event_timestamp;
      cnt_r     <= cnt_base + STAMP_W'(1);
      slot_r    <= slot_nxt;
      if (word > lat_max_r) lat_max_r <= word;
      if (word < lat_min_r) lat_min_r <= word;
      lat_sum_r <= lsum_base + STAMP_W'(word);
      jit_sum_r <= jsum_base + gap;
      if (!first && gap > jit_max_r) jit_max_r <= gap;
      if (!first && gap < jit_min_r) jit_min_r <= gap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (out_ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_read_r  <= rd;
      s1_word_r  <= word;
      s1_gap_r   <= rd ? '0 : gap;
      s1_spike_r <= ev && spike;
    end
  end

  ljsm_ram #(
    .WIDTH (SNAP_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ev),
    .waddr (slot_use),
    .wdata (word),
    .re    (rd),
    .raddr (rslot),
    .rdata (ram_rdata)
  );

  // stats regs change only when a new word replaces the output stage
  assign out_valid         = s1_valid_r;
  assign out_latency_now   = s1_read_r ? ram_rdata : s1_word_r;
  assign out_spike_seen    = s1_spike_r;
  assign out_latency_low   = lat_min_r;
  assign out_latency_high  = lat_max_r;
  assign out_latency_total = lat_sum_r;
  assign out_gap_now       = s1_gap_r;
  assign out_gap_low       = jit_min_r;
  assign out_gap_high      = jit_max_r;
  assign out_gap_total     = jit_sum_r;
  assign out_events_done   = cnt_r;

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> lat_min_r <= lat_max_r)
    else $error("latency min above max");

  a_read_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    rd |=> $stable(cnt_r) && $stable(lat_sum_r) && $stable(slot_r))
    else $error("read word changed state");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LAST_SLOT)
    else $error("ring slot out of range");

  a_spike_event: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_spike_r |-> !s1_read_r && s1_word_r >= SNAP_W'(thresh_r))
    else $error("spike flag without event");

  a_event_starts: assert property (@(posedge clk) disable iff (!rst_n)
    ev |=> started_r && out_valid)
    else $error("event did not start monitor");

endmodule

@@ tb/ljsm_stats_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the latency/jitter statistics monitor: tracks register writes,
// predicts one stats word per accepted input word and compares the out_ channel.
// Depends on ljsm_pkg.
module ljsm_stats_checker
  import ljsm_pkg::*;
#(
  parameter int TICKS_PER_US = 125
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [SNAP_W-1:0]     in_timer_snapshot,
  input  logic [STAMP_W-1:0]    in_event_timestamp,
  input  logic [SLOT_W-1:0]     in_read_slot,

  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [SNAP_W-1:0]     out_latency_now,
  input  logic                  out_spike_seen,
  input  logic [SNAP_W-1:0]     out_latency_low,
  input  logic [SNAP_W-1:0]     out_latency_high,
  input  logic [STAMP_W-1:0]    out_latency_total,
  input  logic [STAMP_W-1:0]    out_gap_now,
  input  logic [STAMP_W-1:0]    out_gap_low,
  input  logic [STAMP_W-1:0]    out_gap_high,
  input  logic [STAMP_W-1:0]    out_gap_total,
  input  logic [STAMP_W-1:0]    out_events_done,

  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  output int                    fail_count,
  output int                    words_pending
);

  typedef struct packed {
    logic [SNAP_W-1:0]  lat_now;
    logic               spike;
    logic [SNAP_W-1:0]  lat_lo;
    logic [SNAP_W-1:0]  lat_hi;
    logic [STAMP_W-1:0] lat_acc;
    logic [STAMP_W-1:0] gap_now;
    logic [STAMP_W-1:0] gap_lo;
    logic [STAMP_W-1:0] gap_hi;
    logic [STAMP_W-1:0] gap_acc;
    logic [STAMP_W-1:0] n_events;
  } stats_word_t;

  logic [SNAP_W-1:0]  period;
  logic [LIMIT_W-1:0] spike_lim;
  logic               armed;
  logic [STAMP_W-1:0] last_stamp;
  logic [STAMP_W-1:0] n_events;
  logic [SNAP_W-1:0]  lat_lo;
  logic [SNAP_W-1:0]  lat_hi;
  logic [STAMP_W-1:0] lat_acc;
  logic [STAMP_W-1:0] gap_lo;
  logic [STAMP_W-1:0] gap_hi;
  logic [STAMP_W-1:0] gap_acc;
  logic [SNAP_W-1:0]  lat_ring [2**SLOT_W];

  stats_word_t stats_q[$];
  int mismatches = 0;
  int queued = 0;

  assign fail_count    = mismatches;
  assign words_pending = queued;

  task automatic report_error(input string msg);
    $display("%0t: stats word mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic predict_stats(input logic req, input logic [SNAP_W-1:0] snap,
                               input logic [STAMP_W-1:0] stamp,
                               input logic [SLOT_W-1:0] slot);
    stats_word_t w;
    logic [SNAP_W-1:0]  lat;
    logic [STAMP_W-1:0] gap;
    w   = '0;
    gap = '0;
    if (req_t'(req) == REQ_TIMER) begin
      lat = period - snap;
      if (!armed) begin
        armed      = 1'b1;
        last_stamp = stamp;
        n_events   = '0;
        gap_acc    = '0;
        lat_acc    = '0;
      end else begin
        gap = stamp - last_stamp;
        if (gap > gap_hi) gap_hi = gap;
        if (gap < gap_lo) gap_lo = gap;
        last_stamp = stamp;
        gap_acc    = gap_acc + gap;
      end
      if (lat > lat_hi) lat_hi = lat;
      if (lat < lat_lo) lat_lo = lat;
      lat_acc = lat_acc + STAMP_W'(lat);
      lat_ring[SLOT_W'(n_events - 64'd1)] = lat;
      n_events = n_events + 64'd1;
      w.spike = (spike_lim != '0) &&
                (64'(lat) >= 64'(spike_lim) * 64'(TICKS_PER_US));
    end else begin
      lat = lat_ring[slot];
    end
    w.lat_now  = lat;
    w.lat_lo   = lat_lo;
    w.lat_hi   = lat_hi;
    w.lat_acc  = lat_acc;
    w.gap_now  = gap;
    w.gap_lo   = gap_lo;
    w.gap_hi   = gap_hi;
    w.gap_acc  = gap_acc;
    w.n_events = n_events;
    stats_q.push_back(w);
  endtask

  always @(posedge clk) begin : scoreboard
    stats_word_t want;
    if (!rst_n) begin
      period     = PERIOD_RST;
      spike_lim  = '0;
      armed      = 1'b0;
      last_stamp = '0;
      n_events   = '0;
      lat_lo     = '1;
      lat_hi     = '0;
      lat_acc    = '0;
      gap_lo     = '1;
      gap_hi     = '0;
      gap_acc    = '0;
      stats_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (stats_q.size() == 0) begin
          report_error("word with no prediction pending");
        end else begin
          want = stats_q.pop_front();
          check_field("latency_now", out_latency_now, want.lat_now);
          check_field("spike_seen", out_spike_seen, want.spike);
          check_field("latency_low", out_latency_low, want.lat_lo);
          check_field("latency_high", out_latency_high, want.lat_hi);
          check_field("latency_total", out_latency_total, want.lat_acc);
          check_field("gap_now", out_gap_now, want.gap_now);
          check_field("gap_low", out_gap_low, want.gap_lo);
          check_field("gap_high", out_gap_high, want.gap_hi);
          check_field("gap_total", out_gap_total, want.gap_acc);
          check_field("events_done", out_events_done, want.n_events);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TIMER_PERIOD: period    = cfg_data[SNAP_W-1:0];
          CFG_SPIKE_LIMIT:  spike_lim = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_stats(in_req_type, in_timer_snapshot, in_event_timestamp, in_read_slot);
    end
    queued = stats_q.size();
  end

endmodule

@@ tb/latency_jitter_stats_monitor_tb.sv @@
`timescale 1ns / 100ps
// Top-level testbench for latency_jitter_stats_monitor: clock, reset, stimulus,
// register programming and verdict. Uses ljsm_pkg, the DUT, ljsm_stats_checker.
module latency_jitter_stats_monitor_tb;
  import ljsm_pkg::*;

  localparam int TICKS_PER_US = 125;
  localparam int SEG_WORDS    = 285;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [SNAP_W-1:0]     in_timer_snapshot;
  logic [STAMP_W-1:0]    in_event_timestamp;
  logic [SLOT_W-1:0]     in_read_slot;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SNAP_W-1:0]     out_latency_now;
  logic                  out_spike_seen;
  logic [SNAP_W-1:0]     out_latency_low;
  logic [SNAP_W-1:0]     out_latency_high;
  logic [STAMP_W-1:0]    out_latency_total;
  logic [STAMP_W-1:0]    out_gap_now;
  logic [STAMP_W-1:0]    out_gap_low;
  logic [STAMP_W-1:0]    out_gap_high;
  logic [STAMP_W-1:0]    out_gap_total;
  logic [STAMP_W-1:0]    out_events_done;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    words_pending;

  int in_idle_pct  = 27;
  int out_idle_pct = 83;

  // stimulus-side shadows: register values, last stamp and written ring slots
  logic [SNAP_W-1:0]  cur_period = PERIOD_RST;
  logic [LIMIT_W-1:0] cur_limit  = '0;
  logic [STAMP_W-1:0] last_stamp = '0;
  logic               any_event  = 1'b0;
  logic [SLOT_W-1:0]  next_slot  = '0;
  bit                 slot_used [2**SLOT_W];
  logic [SLOT_W-1:0]  wr_slots[$];

  latency_jitter_stats_monitor u_top (.*);

  ljsm_stats_checker #(.TICKS_PER_US(TICKS_PER_US)) u_checker (.*);

  always #6 clk = ~clk;

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= out_idle_pct);

  initial begin
    #5_000_000;
    $display("latency_jitter_stats_monitor regression: fail");
    $finish;
  end

  task automatic drive_word(input req_t req, input logic [SNAP_W-1:0] snap,
                            input logic [STAMP_W-1:0] stamp,
                            input logic [SLOT_W-1:0] slot);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_req_type        <= req;
    in_timer_snapshot  <= snap;
    in_event_timestamp <= stamp;
    in_read_slot       <= slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_timer(input logic [SNAP_W-1:0] snap, input logic [STAMP_W-1:0] stamp);
    logic [SLOT_W-1:0] slot;
    if (!any_event) begin
      any_event = 1'b1;
      next_slot = '0;
    end
    slot = next_slot - 1'b1;
    if (!slot_used[slot]) begin
      slot_used[slot] = 1'b1;
      wr_slots.push_back(slot);
    end
    next_slot  = next_slot + 1'b1;
    last_stamp = stamp;
    drive_word(REQ_TIMER, snap, stamp, SLOT_W'($urandom));
  endtask

  task automatic send_read(input logic [SLOT_W-1:0] slot);
    drive_word(REQ_READ, $urandom, {$urandom, $urandom}, slot);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
  endtask

  task automatic program_regs(input logic [SNAP_W-1:0] period, input logic [LIMIT_W-1:0] limit);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TIMER_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= CFG_SPIKE_LIMIT;
    cfg_data  <= CFG_DATA_W'(limit);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    cur_period = period;
    cur_limit  = limit;
  endtask

  function automatic logic [SNAP_W-1:0] pick_snapshot();
    logic [SNAP_W-1:0] thr;
    thr = SNAP_W'(cur_limit) * SNAP_W'(TICKS_PER_US);
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: return cur_period - SNAP_W'($urandom_range(0, 20000));
      6:       return cur_period - thr + 32'd1 - SNAP_W'($urandom_range(0, 2));
      7:       return cur_period;
      8:       return cur_period + 32'd1;
      default: return cur_period - SNAP_W'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic logic [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(0, 9))
      6:       return last_stamp;
      7:       return {$urandom, $urandom};
      8:       return last_stamp - 64'd1;
      9:       return last_stamp + {$urandom, $urandom};
      default: return last_stamp + STAMP_W'($urandom_range(1, 5000));
    endcase
  endfunction

  initial begin
    logic [SNAP_W-1:0]  seg_period;
    logic [LIMIT_W-1:0] seg_limit;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_req_type        = REQ_TIMER;
    in_timer_snapshot  = '0;
    in_event_timestamp = '0;
    in_read_slot       = '0;
    cfg_valid          = 1'b0;
    cfg_index          = CFG_TIMER_PERIOD;
    cfg_data           = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset registers: period 110, spike detection off
    send_timer(32'd0, 64'd0);
    send_read(10'd1023);
    send_timer(32'd110, 64'd5);
    send_timer(32'd111, 64'd5);
    send_timer(32'hFFFF_FFFF, 64'd4);
    send_timer(32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_timer(32'h7FFF_FFFF, 64'd0);
    send_read(10'd0);
    send_read(10'd4);

    program_regs(32'd0, 7'd1);
    send_timer(32'hFFFF_FF83, 64'd100);
    send_timer(32'hFFFF_FF84, 64'd200);
    send_timer(32'd0, 64'd300);

    program_regs(32'hFFFF_FFFF, 7'd127);
    send_timer(32'hFFFF_FFFF - 32'd15875, 64'd400);
    send_timer(32'hFFFF_FFFF - 32'd15874, 64'd500);
    send_timer(32'd0, 64'd600);

    program_regs(32'hDEAD_BEEF, 7'd100);
    send_timer(32'hDEAD_BEEF - 32'd12500, 64'd700);
    send_timer(32'hDEAD_BEEF - 32'd12499, 64'd800);
    send_read(10'd3);

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        1:       seg_period = '0;
        3:       seg_period = '1;
        5:       seg_period = PERIOD_RST;
        default: seg_period = $urandom;
      endcase
      case (seg)
        0:       seg_limit = '0;
        2:       seg_limit = 7'd127;
        4:       seg_limit = 7'd1;
        default: seg_limit = LIMIT_W'($urandom_range(1, 127));
      endcase
      program_regs(seg_period, seg_limit);
      in_idle_pct  = (seg < 2) ? 27 : (seg < 4) ? 83 : 0;
      out_idle_pct = (seg < 2) ? 83 : (seg < 4) ? 27 : 0;
      for (int i = 0; i < SEG_WORDS; i++) begin
        if (i == SEG_WORDS / 2)
          settle();
        if (wr_slots.size() != 0 && $urandom_range(0, 99) < 20)
          send_read(wr_slots[$urandom_range(0, wr_slots.size() - 1)]);
        else
          send_timer(pick_snapshot(), pick_stamp());
      end
    end

    in_valid <= 1'b0;
    for (int k = 0; k < 4000 && words_pending != 0; k++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("latency_jitter_stats_monitor regression: pass");
    end else begin
      $display("latency_jitter_stats_monitor regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ljsm_pkg.sv
hw/rtl/ljsm_ram.sv
hw/rtl/latency_jitter_stats_monitor.sv
tb/ljsm_stats_checker.sv
tb/latency_jitter_stats_monitor_tb.sv
